// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is low.
`define CHK_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bbsd_pkg.sv -----
// Shared types and constants of the balanced base slot decoder.
`timescale 1ns / 1ps
`default_nettype none

package bbsd_pkg;

  localparam int unsigned MAX_COEFFS  = 4096;
  localparam int unsigned COEFF_W     = 64;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned SLOT_W      = 13;
  localparam int unsigned BASE_W      = 31;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Indexes of the configuration registers.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_LEN      = 2'd0,
    REG_DIGIT_BASE    = 2'd1,
    REG_MODULUS       = 2'd2,
    REG_NARROW_RESULT = 2'd3
  } cfg_reg_t;

  // One classified coefficient on its way from the front to the back.
  typedef struct packed {
    logic               first;
    logic               last;
    logic               top;
    logic               neg;
    logic               bad;
    logic [COEFF_W-1:0] mag;
  } bbsd_item_t;

endpackage

`default_nettype wire

// ----- src/bbsd_front.sv -----
// Front part: accepts coefficients, finds slot tops and classifies the digit.
`timescale 1ns / 1ps
`default_nettype none

module bbsd_front #(
  parameter int unsigned MAX_COEFFS = bbsd_pkg::MAX_COEFFS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // coefficient residue [63:0], coefficient index [75:64], zero fill [79:76]
  input  wire logic [bbsd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // first_coeff
  input  wire logic                                 s_axis_tuser,
  input  wire logic                                 s_axis_tlast,
  input  wire logic [bbsd_pkg::SLOT_W-1:0]          slot_len,
  input  wire logic [bbsd_pkg::COEFF_W-1:0]         modulus,
  output logic                                      q_push,
  output bbsd_pkg::bbsd_item_t                      q_item,
  input  wire logic                                 q_full
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_WORK = 2'b10
  } fstate_t;

  fstate_t                          state;
  logic [bbsd_pkg::COEFF_W-1:0]     coeff;
  logic [bbsd_pkg::POS_W-1:0]       pos;
  logic                             first;
  logic                             last;
  logic [bbsd_pkg::SLOT_W-1:0]      rem_hi;

  logic [bbsd_pkg::SLOT_W-1:0]      ss_eff;
  logic [bbsd_pkg::SLOT_W-1:0]      rem_hi_next;
  logic [bbsd_pkg::SLOT_W-1:0]      rem;
  logic [bbsd_pkg::COEFF_W-1:0]     smear;
  logic [bbsd_pkg::COEFF_W-1:0]     mag;
  logic                             neg;
  logic                             bad;

  // Six restoring remainder steps, one dividend bit each, most significant first.
  function automatic logic [bbsd_pkg::SLOT_W-1:0] div_steps(
    input logic [bbsd_pkg::SLOT_W-1:0] r_in,
    input logic [5:0]                  bits,
    input logic [bbsd_pkg::SLOT_W-1:0] d
  );
    logic [bbsd_pkg::SLOT_W:0]   t;
    logic [bbsd_pkg::SLOT_W-1:0] r;
    r = r_in;
    for (int i = 5; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r = t[bbsd_pkg::SLOT_W-1:0];
    end
    return r;
  endfunction

  assign ss_eff        = (slot_len == '0) ? bbsd_pkg::SLOT_W'(1) : slot_len;
  assign rem_hi_next   = div_steps('0, s_axis_tdata[75:70], ss_eff);
  assign rem           = div_steps(rem_hi, pos[5:0], ss_eff);
  assign s_axis_tready = (state == F_IDLE);
  assign q_push        = (state == F_WORK) && !q_full;

  always_comb begin
    smear = modulus;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    smear = smear | (smear >> 32);
    neg = {coeff, 1'b0} >= {1'b0, modulus};
    mag = neg ? (modulus - coeff) : coeff;
    bad = (modulus == '0)
        || ({20'b0, pos} >= 32'(MAX_COEFFS))
        || ((coeff & ~smear) != '0)
        || (neg && (coeff > modulus))
        || mag[bbsd_pkg::COEFF_W-1];
    q_item.first = first;
    q_item.last  = last;
    q_item.top   = (rem == (ss_eff - bbsd_pkg::SLOT_W'(1)));
    q_item.neg   = neg;
    q_item.bad   = bad;
    q_item.mag   = mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (s_axis_tvalid) begin
            state <= F_WORK;
          end
        end
        F_WORK: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      coeff  <= s_axis_tdata[63:0];
      pos    <= s_axis_tdata[75:64];
      first  <= s_axis_tuser;
      last   <= s_axis_tlast;
      rem_hi <= rem_hi_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/bbsd_queue.sv -----
// Short queue of classified items between the front and the back parts.
`timescale 1ns / 1ps
`default_nettype none

module bbsd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  bbsd_pkg::bbsd_item_t      push_item,
  output logic                      full,
  input  wire logic                 pop,
  output bbsd_pkg::bbsd_item_t      pop_item,
  output logic                      valid
);

  localparam int unsigned DEPTH = bbsd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bbsd_pkg::bbsd_item_t entries [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop && valid) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if ((push && !full) && !(pop && valid)) begin
        count <= count + CNT_W'(1);
      end else if (!(push && !full) && (pop && valid)) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/bbsd_back.sv -----
// Back part: multiply-accumulate of the digits, error tracking and result register.
`timescale 1ns / 1ps
`default_nettype none

module bbsd_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  bbsd_pkg::bbsd_item_t                q_item,
  output logic                                q_pop,
  input  wire logic [bbsd_pkg::BASE_W-1:0]    digit_base,
  input  wire logic                           narrow_result,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // decoded_value [63:0]
  output logic [bbsd_pkg::COEFF_W-1:0]        m_axis_tdata,
  // decode_error
  output logic                                m_axis_tuser
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_COMB = 5'b00100,
    B_ADD  = 5'b01000,
    B_EMIT = 5'b10000
  } bstate_t;

  localparam int unsigned W = bbsd_pkg::COEFF_W;

  bstate_t        state;
  logic [W-1:0]   acc;
  logic           err_seen;
  logic [W-1:0]   next_val;
  logic [62:0]    p_lo;
  logic [31:0]    p_hi;
  logic           cur_last;
  logic           cur_top;
  logic           cur_neg;
  logic [W-1:0]   cur_mag;

  logic           skip;
  logic [W-1:0]   sum;
  logic           flip;
  logic           ovf;
  logic           narrow_bad;
  logic           out_err;
  logic           emit_fire;

  assign q_pop     = (state == B_IDLE) && q_valid;
  assign emit_fire = (state == B_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    skip       = q_item.bad || (err_seen && !q_item.first);
    sum        = cur_neg ? (next_val - cur_mag) : (next_val + cur_mag);
    flip       = cur_top && (next_val[W-1] != acc[W-1]);
    ovf        = (next_val[W-1] == cur_neg) && (sum[W-1] != next_val[W-1]);
    narrow_bad = narrow_result && !((&acc[W-1:31]) || !(|acc[W-1:31]));
    out_err    = err_seen || narrow_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      acc           <= '0;
      err_seen      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            if (q_item.first) begin
              acc <= '0;
            end
            err_seen <= skip;
            if (skip) begin
              state <= q_item.last ? B_EMIT : B_IDLE;
            end else begin
              state <= q_item.top ? B_MUL : B_ADD;
            end
          end
        end
        B_MUL: begin
          state <= B_COMB;
        end
        B_COMB: begin
          state <= B_ADD;
        end
        B_ADD: begin
          if (flip || ovf) begin
            err_seen <= 1'b1;
          end else begin
            acc <= sum;
          end
          state <= cur_last ? B_EMIT : B_IDLE;
        end
        B_EMIT: begin
          if (emit_fire) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_last <= q_item.last;
      cur_top  <= q_item.top;
      cur_neg  <= q_item.neg;
      cur_mag  <= q_item.mag;
      next_val <= q_item.first ? '0 : acc;
    end
    if (state == B_MUL) begin
      p_lo <= {31'b0, acc[31:0]} * {32'b0, digit_base};
      p_hi <= acc[W-1:32] * {1'b0, digit_base};
    end
    if (state == B_COMB) begin
      next_val <= {1'b0, p_lo} + {p_hi, 32'b0};
    end
    if (emit_fire) begin
      m_axis_tdata <= out_err ? '0 : acc;
      m_axis_tuser <= out_err;
    end
  end

endmodule

`default_nettype wire

// ----- src/balanced_base_slot_decoder_top.sv -----
// Top level of the balanced base slot decoder: configuration and part wiring.
//
// Use: coefficients of one polynomial enter on the s_axis channel, highest
// index first; tuser marks the first item and clears the running value and
// error, tlast marks index zero. For each tlast item one result leaves on
// m_axis: the decoded signed value in tdata and the error flag in tuser.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// no item is in flight; each write takes effect at the next clock edge.
// The front accepts an item in its idle state, starting the 12-step remainder
// for the slot test; its work state ends it, classifies the digit and pushes
// the item, and the front takes no new item before that push. The back takes
// a non-top item through idle and add, a slot top through idle, multiply,
// combine and add for the split 64x31 multiply and carry add, and an item
// skipped after an error only through idle; a tlast item enters the emit
// state for the result register. A two-entry queue lets the front keep taking
// items while the back works, and a stalled m_axis receiver holds the result
// register and then, through the queue, the input. Synchronous reset empties
// the queue and result register and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module balanced_base_slot_decoder_top #(
  parameter int unsigned MAX_COEFFS = bbsd_pkg::MAX_COEFFS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // coefficient residue [63:0], coefficient index [75:64], zero fill [79:76]
  input  wire logic [bbsd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // first_coeff
  input  wire logic                                 s_axis_tuser,
  input  wire logic                                 s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // decoded_value [63:0]
  output logic [bbsd_pkg::COEFF_W-1:0]              m_axis_tdata,
  // decode_error
  output logic                                      m_axis_tuser,
  input  wire logic                                 cfg_write,
  input  wire logic [bbsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bbsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [bbsd_pkg::SLOT_W-1:0]  SLOT_LEN_RST = 13'd1;
  localparam logic [bbsd_pkg::BASE_W-1:0]  DIGIT_BASE_RST = 31'd3;
  localparam logic [bbsd_pkg::COEFF_W-1:0] MODULUS_RST = 64'd65537;

  logic [bbsd_pkg::SLOT_W-1:0]   slot_len;
  logic [bbsd_pkg::BASE_W-1:0]   digit_base;
  logic [bbsd_pkg::COEFF_W-1:0]  modulus;
  logic                          narrow_result;

  logic                          q_push;
  logic                          q_full;
  logic                          q_pop;
  logic                          q_valid;
  bbsd_pkg::bbsd_item_t          q_in_item;
  bbsd_pkg::bbsd_item_t          q_out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_len      <= SLOT_LEN_RST;
      digit_base    <= DIGIT_BASE_RST;
      modulus       <= MODULUS_RST;
      narrow_result <= 1'b0;
    end else if (cfg_write) begin
      unique case (bbsd_pkg::cfg_reg_t'(cfg_index))
        bbsd_pkg::REG_SLOT_LEN:      slot_len      <= cfg_data[bbsd_pkg::SLOT_W-1:0];
        bbsd_pkg::REG_DIGIT_BASE:    digit_base    <= cfg_data[bbsd_pkg::BASE_W-1:0];
        bbsd_pkg::REG_MODULUS:       modulus       <= cfg_data;
        bbsd_pkg::REG_NARROW_RESULT: narrow_result <= cfg_data[0];
        default:                     narrow_result <= narrow_result;
      endcase
    end
  end

  bbsd_front #(
    .MAX_COEFFS (MAX_COEFFS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .slot_len      (slot_len),
    .modulus       (modulus),
    .q_push        (q_push),
    .q_item        (q_in_item),
    .q_full        (q_full)
  );

  bbsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .valid     (q_valid)
  );

  bbsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_out_item),
    .q_pop         (q_pop),
    .digit_base    (digit_base),
    .narrow_result (narrow_result),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- src/bbsd_checker.sv -----
// Port-level checker of the balanced base slot decoder and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbsd_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [bbsd_pkg::COEFF_W-1:0]      m_axis_tdata,
  input wire logic                              m_axis_tuser
);

  // A stalled result keeps its value until it is taken.
  `CHK_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // An error result always carries a zero value.
  `CHK_ASSERT(a_err_zero, clk, rst, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "error result with nonzero value")

  // Reset leaves no result pending.
  `CHK_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid, "result valid after reset")

  // Input ready drops after every accepted item, while the front works on it.
  `CHK_ASSERT(a_in_gap, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken on consecutive cycles")

endmodule

bind balanced_base_slot_decoder_top bbsd_checker u_bbsd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
